### design/sti_pkg.sv
`default_nettype none
package sti_pkg;

    localparam int MaxSamples    = 1024;
    localparam int MaxComponents = 8;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_ACCEPTED = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    // Request types.
    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_QUERY  = 1'b1
    } req_t;

    // Control sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_CHK,
        S_Q_RD_FIRST,
        S_Q_RD_LAST,
        S_Q_CHK,
        S_SEARCH_RD,
        S_SEARCH_CHK,
        S_BRK_RD,
        S_VAL_RD,
        S_VAL_WAIT,
        S_DIV,
        S_EMIT,
        S_OUT
    } state_t;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

### design/sampled_trajectory_interpolator.sv
`default_nettype none
// Sampled trajectory interpolator.
// Requests arrive on the s_ channel (valid/ready); results leave on the
// m_ channel. An append request carries one component; the last component
// of a sample gives one result with status accepted or rejected, the
// others give none. A query gives one out-of-range result or one result
// per component, the final one marked by m_last.
// Sequence: an append that completes a sample is order-checked before its
// result is shown; any other component returns straight to idle. A query
// reads the first and last times for the range check, runs a binary search
// (up to 11 steps for a full table of 1024) and fetches the bracketing
// times, then passes each component through the 64-step serial divider
// and its setup (both skipped on a hit at the last time).
// One request is handled at a time; s_ready is low while one is in progress.
// A result waits in the output register while the receiver stalls, and
// the block holds until it is taken.
// After reset the table is empty, num_components is 1 and no partial
// sample is pending. The memories are not cleared.
module sampled_trajectory_interpolator #(
    parameter int MAX_SAMPLES    = sti_pkg::MaxSamples,
    parameter int MAX_COMPONENTS = sti_pkg::MaxComponents
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [3:0]         cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire logic [31:0]        s_time_stamp,
    input  wire logic signed [31:0] s_comp_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_out_value,
    output logic [2:0]              m_comp_index,
    output logic [1:0]              m_status,
    output logic                    m_last
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int NW = AW + 1;
    localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int KW = CW + 1;

    sti_pkg::state_t state_reg, state_next;

    logic [NW-1:0] count_reg, count_next;
    logic [KW-1:0] ccnt_reg, ccnt_next;
    logic [31:0]   ptime_reg, ptime_next;
    logic [3:0]    ncomp_reg;
    logic [31:0]   qtime_reg, qtime_next;
    logic [31:0]   vin_reg, vin_next;
    logic [KW-1:0] cidx_reg, cidx_next;
    logic [NW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0]   ta_reg, ta_next, tb_reg, tb_next;
    logic signed [31:0] va_reg, va_next;
    logic          exact_reg, exact_next;
    logic [NW-1:0] mid;

    logic          mv_reg, mv_next;
    logic [31:0]   mval_reg, mval_next;
    logic [2:0]    midx_reg, midx_next;
    logic [1:0]    mst_reg, mst_next;
    logic          mlast_reg, mlast_next;

    logic [KW-1:0] nact;
    logic [4:0]    nclip;

    // Memory ports.
    logic          t_we, v_we;
    logic [AW-1:0] t_waddr, t_raddr, v_wrow, v_rrow;
    logic [CW-1:0] v_wcol, v_rcol;
    logic [31:0]   t_wdata, t_rdata, v_wdata, v_rdata;

    sti_pkg::div_ctrl_t div_ctrl;
    sti_pkg::div_stat_t div_stat;
    logic [63:0]   div_q;
    logic [32:0]   dv;
    logic [31:0]   mag;
    logic          neg_reg;
    logic [31:0]   mag_reg;
    logic [63:0]   prod_reg;
    logic [31:0]   sum;
    logic [1:0]    dphase_reg, dphase_next;

    // Active component count, clipped to the supported range.
    always_comb begin
        nclip = {1'b0, ncomp_reg};
        if (nclip == 5'd0) begin
            nclip = 5'd1;
        end
        if (nclip > 5'(MAX_COMPONENTS)) begin
            nclip = 5'(MAX_COMPONENTS);
        end
        nact = KW'(nclip);
    end

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    sti_store #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .MAX_COMPONENTS(MAX_COMPONENTS)
    ) u_store (
        .aclk   (aclk),
        .t_we   (t_we),
        .t_waddr(t_waddr),
        .t_wdata(t_wdata),
        .t_raddr(t_raddr),
        .t_rdata(t_rdata),
        .v_we   (v_we),
        .v_wrow (v_wrow),
        .v_wcol (v_wcol),
        .v_wdata(v_wdata),
        .v_rrow (v_rrow),
        .v_rcol (v_rcol),
        .v_rdata(v_rdata)
    );

    sti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .dividend(prod_reg),
        .divisor (tb_reg - ta_reg),
        .stat    (div_stat),
        .quotient(div_q)
    );

    assign dv  = {v_rdata[31], v_rdata} - {va_reg[31], va_reg};
    assign mag = dv[32] ? 32'(-dv) : dv[31:0];
    assign sum = neg_reg ? 32'(va_reg) - div_q[31:0] : 32'(va_reg) + div_q[31:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sti_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == sti_pkg::REQ_APPEND) begin
                        state_next = sti_pkg::S_APP_RD;
                    end else begin
                        state_next = sti_pkg::S_Q_RD_FIRST;
                    end
                end
            end
            sti_pkg::S_APP_RD: begin
                if (ccnt_next == '0) begin
                    state_next = sti_pkg::S_APP_CHK;
                end else begin
                    state_next = sti_pkg::S_IDLE;
                end
            end
            sti_pkg::S_APP_CHK:    state_next = sti_pkg::S_OUT;
            sti_pkg::S_Q_RD_FIRST: state_next = sti_pkg::S_Q_RD_LAST;
            sti_pkg::S_Q_RD_LAST:  state_next = sti_pkg::S_Q_CHK;
            sti_pkg::S_Q_CHK: begin
                if (count_reg < NW'(2) || qtime_reg < ta_reg || qtime_reg > t_rdata) begin
                    state_next = sti_pkg::S_OUT;
                end else if (qtime_reg == t_rdata) begin
                    state_next = sti_pkg::S_VAL_RD;
                end else begin
                    state_next = sti_pkg::S_SEARCH_RD;
                end
            end
            sti_pkg::S_SEARCH_RD: begin
                if (lo_reg < hi_reg) begin
                    state_next = sti_pkg::S_SEARCH_CHK;
                end else begin
                    state_next = sti_pkg::S_BRK_RD;
                end
            end
            sti_pkg::S_SEARCH_CHK: state_next = sti_pkg::S_SEARCH_RD;
            sti_pkg::S_BRK_RD:     state_next = sti_pkg::S_VAL_RD;
            sti_pkg::S_VAL_RD:     state_next = sti_pkg::S_VAL_WAIT;
            sti_pkg::S_VAL_WAIT: begin
                if (exact_reg) begin
                    state_next = sti_pkg::S_EMIT;
                end else begin
                    state_next = sti_pkg::S_DIV;
                end
            end
            sti_pkg::S_DIV: begin
                if (div_stat.done) begin
                    state_next = sti_pkg::S_EMIT;
                end
            end
            sti_pkg::S_EMIT: state_next = sti_pkg::S_OUT;
            sti_pkg::S_OUT: begin
                if (m_ready) begin
                    if (mlast_reg) begin
                        state_next = sti_pkg::S_IDLE;
                    end else begin
                        state_next = sti_pkg::S_VAL_RD;
                    end
                end
            end
            default: state_next = sti_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        count_next = count_reg;
        ccnt_next  = ccnt_reg;
        ptime_next = ptime_reg;
        qtime_next = qtime_reg;
        vin_next   = vin_reg;
        cidx_next  = cidx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        va_next    = va_reg;
        exact_next = exact_reg;
        mv_next    = mv_reg;
        mval_next  = mval_reg;
        midx_next  = midx_reg;
        mst_next   = mst_reg;
        mlast_next = mlast_reg;
        s_ready    = 1'b0;
        t_we       = 1'b0;
        t_waddr    = count_reg[AW-1:0];
        t_wdata    = ptime_reg;
        t_raddr    = '0;
        v_we       = 1'b0;
        v_wrow     = count_reg[AW-1:0];
        v_wcol     = '0;
        v_wdata    = vin_reg;
        v_rrow     = '0;
        v_rcol     = cidx_reg[CW-1:0];
        div_ctrl.start = 1'b0;

        unique case (state_reg)
            sti_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                qtime_next = s_time_stamp;
                vin_next   = s_comp_value;
                if (s_valid && s_req_type == sti_pkg::REQ_APPEND &&
                    (ccnt_reg >= nact || ccnt_reg == '0)) begin
                    ptime_next = s_time_stamp;
                end
            end
            sti_pkg::S_APP_RD: begin
                // Store the component; read the previous time for the order check.
                if (ccnt_reg >= nact) begin
                    ccnt_next = KW'(1);
                    v_wcol    = '0;
                end else begin
                    ccnt_next = ccnt_reg + KW'(1);
                    v_wcol    = ccnt_reg[CW-1:0];
                end
                v_we = (count_reg < NW'(MAX_SAMPLES));
                if (ccnt_next >= nact) begin
                    ccnt_next = '0;
                end
                t_raddr = AW'(count_reg - NW'(1));
            end
            sti_pkg::S_APP_CHK: begin
                mv_next    = 1'b1;
                mval_next  = '0;
                midx_next  = '0;
                mlast_next = 1'b1;
                if (count_reg < NW'(MAX_SAMPLES) &&
                    (count_reg == '0 || ptime_reg > t_rdata)) begin
                    t_we       = 1'b1;
                    count_next = count_reg + NW'(1);
                    mst_next   = sti_pkg::ST_ACCEPTED;
                end else begin
                    mst_next   = sti_pkg::ST_REJECTED;
                end
            end
            sti_pkg::S_Q_RD_FIRST: begin
                t_raddr = '0;
            end
            sti_pkg::S_Q_RD_LAST: begin
                ta_next = t_rdata;
                t_raddr = AW'(count_reg - NW'(1));
            end
            sti_pkg::S_Q_CHK: begin
                cidx_next  = '0;
                lo_next    = '0;
                hi_next    = count_reg;
                exact_next = (qtime_reg == t_rdata);
                lo_next    = (qtime_reg == t_rdata) ? count_reg - NW'(1) : '0;
                mv_next    = 1'b1;
                mval_next  = '0;
                midx_next  = '0;
                mst_next   = sti_pkg::ST_RANGE;
                mlast_next = 1'b1;
                if (!(count_reg < NW'(2) || qtime_reg < ta_reg || qtime_reg > t_rdata)) begin
                    mv_next = 1'b0;
                end
            end
            sti_pkg::S_SEARCH_RD: begin
                t_raddr = mid[AW-1:0];
                if (!(lo_reg < hi_reg)) begin
                    t_raddr = AW'(lo_reg - NW'(1));
                end
            end
            sti_pkg::S_SEARCH_CHK: begin
                if (t_rdata > qtime_reg) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid + NW'(1);
                end
            end
            sti_pkg::S_BRK_RD: begin
                ta_next = t_rdata;
                t_raddr = lo_reg[AW-1:0];
            end
            sti_pkg::S_VAL_RD: begin
                if (!exact_reg) begin
                    tb_next = (lo_reg == hi_reg && cidx_reg == '0) ? t_rdata : tb_reg;
                end
                v_rrow = exact_reg ? lo_reg[AW-1:0] : AW'(lo_reg - NW'(1));
            end
            sti_pkg::S_VAL_WAIT: begin
                va_next = v_rdata;
                v_rrow  = lo_reg[AW-1:0];
            end
            sti_pkg::S_DIV: begin
                div_ctrl.start = (dphase_reg == 2'd2);
            end
            sti_pkg::S_EMIT: begin
                mv_next    = 1'b1;
                mval_next  = exact_reg ? va_reg : sum;
                midx_next  = 3'(cidx_reg);
                mst_next   = sti_pkg::ST_OK;
                mlast_next = (cidx_reg + KW'(1) == nact);
            end
            sti_pkg::S_OUT: begin
                if (m_ready) begin
                    mv_next   = 1'b0;
                    cidx_next = cidx_reg + KW'(1);
                end
            end
            default: ;
        endcase
    end

    // Divider launch: sign and magnitude, then product, then start.
    always_comb begin
        dphase_next = dphase_reg;
        if (state_reg == sti_pkg::S_DIV) begin
            if (dphase_reg != 2'd3) begin
                dphase_next = dphase_reg + 2'd1;
            end
        end else begin
            dphase_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sti_pkg::S_IDLE;
            count_reg  <= '0;
            ccnt_reg   <= '0;
            ptime_reg  <= '0;
            ncomp_reg  <= 4'd1;
            mv_reg     <= 1'b0;
            dphase_reg <= 2'd0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ccnt_reg   <= cfg_we ? '0 : ccnt_next;
            ptime_reg  <= ptime_next;
            mv_reg     <= mv_next;
            dphase_reg <= dphase_next;
            if (cfg_we) begin
                ncomp_reg <= cfg_wdata;
            end
        end
        qtime_reg <= qtime_next;
        vin_reg   <= vin_next;
        cidx_reg  <= cidx_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        va_reg    <= va_next;
        exact_reg <= exact_next;
        mval_reg  <= mval_next;
        midx_reg  <= midx_next;
        mst_reg   <= mst_next;
        mlast_reg <= mlast_next;
        if (state_reg == sti_pkg::S_DIV && dphase_reg == 2'd0) begin
            neg_reg <= dv[32];
            mag_reg <= mag;
        end
        if (state_reg == sti_pkg::S_DIV && dphase_reg == 2'd1) begin
            prod_reg <= 64'(mag_reg) * 64'(qtime_reg - ta_reg);
        end
    end

    assign m_valid      = mv_reg & (state_reg == sti_pkg::S_OUT);
    assign m_out_value  = mval_reg;
    assign m_comp_index = midx_reg;
    assign m_status     = mst_reg;
    assign m_last       = mlast_reg;

    // A result is only shown while the sequencer waits on the receiver.
    a_valid_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == sti_pkg::S_OUT)
        else $error("result shown outside output state");

    // No request is taken while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken during result");

    // The sample count never exceeds the table depth.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(MAX_SAMPLES))
        else $error("sample count overflow");

endmodule
`default_nettype wire

### design/sti_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle: 64-bit dividend over 32-bit divisor.
module sti_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sti_pkg::div_ctrl_t   ctrl,
    input  wire logic [63:0]          dividend,
    input  wire logic [31:0]          divisor,
    output sti_pkg::div_stat_t        stat,
    output logic [63:0]               quotient
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [32:0] shifted;

    // One shift and subtract step per cycle.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        if (ctrl.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[33]) begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
endmodule
`default_nettype wire

### design/sti_store.sv
`default_nettype none
// Sample time and value memories, one write and one registered read each.
module sti_store #(
    parameter int MAX_SAMPLES    = sti_pkg::MaxSamples,
    parameter int MAX_COMPONENTS = sti_pkg::MaxComponents,
    localparam int AW = $clog2(MAX_SAMPLES),
    localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
    input  wire logic          aclk,
    input  wire logic          t_we,
    input  wire logic [AW-1:0] t_waddr,
    input  wire logic [31:0]   t_wdata,
    input  wire logic [AW-1:0] t_raddr,
    output logic [31:0]        t_rdata,
    input  wire logic          v_we,
    input  wire logic [AW-1:0] v_wrow,
    input  wire logic [CW-1:0] v_wcol,
    input  wire logic [31:0]   v_wdata,
    input  wire logic [AW-1:0] v_rrow,
    input  wire logic [CW-1:0] v_rcol,
    output logic [31:0]        v_rdata
);
    localparam int VDEPTH = MAX_SAMPLES * (1 << CW);

    logic [31:0] times_mem  [MAX_SAMPLES];
    logic [31:0] values_mem [VDEPTH];

    // Time memory.
    always_ff @(posedge aclk) begin
        if (t_we) begin
            times_mem[t_waddr] <= t_wdata;
        end
        t_rdata <= times_mem[t_raddr];
    end

    // Value memory, addressed by row and component.
    always_ff @(posedge aclk) begin
        if (v_we) begin
            values_mem[{v_wrow, v_wcol}] <= v_wdata;
        end
        v_rdata <= values_mem[{v_rrow, v_rcol}];
    end
endmodule
`default_nettype wire

### tb/sampled_trajectory_interpolator_test.sv
`timescale 1ns / 1ps

module sampled_trajectory_interpolator_test;

    localparam int IdleLimit = 5000;

    // One output beat of the block.
    typedef struct {
        logic [31:0]      value;
        logic [2:0]       index;
        sti_pkg::status_t status;
        logic             last;
    } beat_t;

    // One row of the directed stimulus table.
    typedef struct {
        sti_pkg::req_t    req;
        logic [31:0]      ts;
        logic [31:0]      val;
        bit               typed;
        sti_pkg::status_t status;
    } step_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [31:0] s_time_stamp = 32'd0;
    logic signed [31:0] s_comp_value = 32'sd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_out_value;
    logic [2:0]  m_comp_index;
    logic [1:0]  m_status;
    logic        m_last;

    // Shadow of the table and control state.
    logic [31:0] knot_times [sti_pkg::MaxSamples];
    logic [31:0] knot_vals [sti_pkg::MaxSamples][sti_pkg::MaxComponents];
    logic [sti_pkg::MaxComponents-1:0] knot_written [sti_pkg::MaxSamples];
    int unsigned knot_count;
    int unsigned comp_fill;
    logic [31:0] held_time;
    logic [3:0]  comp_cfg;

    beat_t expected_results [$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    bit stall_mode = 1'b0;

    step_row_t dir_rows [17] = '{
        '{sti_pkg::REQ_QUERY,  32'd0,         32'd0,         1'b1, sti_pkg::ST_RANGE},
        '{sti_pkg::REQ_QUERY,  32'hFFFF_FFFF, 32'd0,         1'b1, sti_pkg::ST_RANGE},
        '{sti_pkg::REQ_APPEND, 32'd100,       32'h7FFF_FFFF, 1'b1, sti_pkg::ST_ACCEPTED},
        '{sti_pkg::REQ_QUERY,  32'd100,       32'd0,         1'b1, sti_pkg::ST_RANGE},
        '{sti_pkg::REQ_APPEND, 32'd100,       32'd1,         1'b1, sti_pkg::ST_REJECTED},
        '{sti_pkg::REQ_APPEND, 32'd50,        32'd2,         1'b1, sti_pkg::ST_REJECTED},
        '{sti_pkg::REQ_APPEND, 32'd300,       32'h8000_0000, 1'b1, sti_pkg::ST_ACCEPTED},
        '{sti_pkg::REQ_QUERY,  32'd99,        32'd0,         1'b1, sti_pkg::ST_RANGE},
        '{sti_pkg::REQ_QUERY,  32'd301,       32'd0,         1'b1, sti_pkg::ST_RANGE},
        '{sti_pkg::REQ_QUERY,  32'd100,       32'd0,         1'b0, sti_pkg::ST_OK},
        '{sti_pkg::REQ_QUERY,  32'd200,       32'd0,         1'b0, sti_pkg::ST_OK},
        '{sti_pkg::REQ_QUERY,  32'd299,       32'd0,         1'b0, sti_pkg::ST_OK},
        '{sti_pkg::REQ_QUERY,  32'd300,       32'd0,         1'b0, sti_pkg::ST_OK},
        '{sti_pkg::REQ_APPEND, 32'd400,       32'hFFFF_FFFF, 1'b1, sti_pkg::ST_ACCEPTED},
        '{sti_pkg::REQ_QUERY,  32'd350,       32'd0,         1'b0, sti_pkg::ST_OK},
        '{sti_pkg::REQ_QUERY,  32'd400,       32'd0,         1'b0, sti_pkg::ST_OK},
        '{sti_pkg::REQ_APPEND, 32'd5,         32'd0,         1'b1, sti_pkg::ST_REJECTED}
    };

    sampled_trajectory_interpolator u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_time_stamp (s_time_stamp),
        .s_comp_value (s_comp_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_comp_index (m_comp_index),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Components per sample after clamping of the register.
    function automatic int unsigned live_comps();
        if (comp_cfg == 4'd0) return 1;
        if (comp_cfg > sti_pkg::MaxComponents) return sti_pkg::MaxComponents;
        return comp_cfg;
    endfunction

    // Index of the first stored time above t.
    function automatic int unsigned upper_knot(logic [31:0] t);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = knot_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (knot_times[mid] > t) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic bit out_of_span(logic [31:0] t);
        return knot_count < 2 || t < knot_times[0] || t > knot_times[knot_count-1];
    endfunction

    // Linear blend with the offset truncated toward zero.
    function automatic logic [31:0] blend(logic [31:0] a_raw, logic [31:0] b_raw,
                                          logic [31:0] dt, logic [31:0] h);
        longint va;
        longint vb;
        longint dv;
        longint unsigned mag;
        longint unsigned off;
        va = longint'($signed(a_raw));
        vb = longint'($signed(b_raw));
        dv = vb - va;
        mag = (dv < 0) ? longint'(-dv) : longint'(dv);
        off = (mag * {32'd0, dt}) / {32'd0, h};
        return (dv < 0) ? 32'(va - longint'(off)) : 32'(va + longint'(off));
    endfunction

    // True when a query at t touches only components that have been written.
    function automatic bit query_reads_written(logic [31:0] t);
        int unsigned b;
        int unsigned n;
        n = live_comps();
        if (out_of_span(t)) return 1'b1;
        b = upper_knot(t);
        for (int unsigned j = 0; j < n; j++) begin
            if (b >= knot_count) begin
                if (!knot_written[knot_count-1][j]) return 1'b0;
            end else if (!knot_written[b-1][j] || !knot_written[b][j]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Works out the beats that one accepted request produces.
    function automatic void interp_predict(sti_pkg::req_t rq, logic [31:0] t,
                                           logic [31:0] v);
        int unsigned n;
        int unsigned c;
        int unsigned b;
        int unsigned row;
        bit ok;
        beat_t bt;
        n = live_comps();
        if (rq == sti_pkg::REQ_APPEND) begin
            c = (comp_fill >= n) ? 0 : comp_fill;
            if (c == 0) held_time = t;
            if (knot_count < sti_pkg::MaxSamples) begin
                knot_vals[knot_count][c] = v;
                knot_written[knot_count][c] = 1'b1;
            end
            if (c + 1 < n) begin
                comp_fill = c + 1;
                return;
            end
            comp_fill = 0;
            ok = knot_count < sti_pkg::MaxSamples;
            if (ok && knot_count > 0 && held_time <= knot_times[knot_count-1]) ok = 1'b0;
            if (ok) begin
                knot_times[knot_count] = held_time;
                knot_count++;
            end
            bt = '{32'd0, 3'd0, ok ? sti_pkg::ST_ACCEPTED : sti_pkg::ST_REJECTED, 1'b1};
            expected_results = {expected_results, bt};
            return;
        end
        if (out_of_span(t)) begin
            bt = '{32'd0, 3'd0, sti_pkg::ST_RANGE, 1'b1};
            expected_results = {expected_results, bt};
            return;
        end
        b = upper_knot(t);
        for (int unsigned j = 0; j < n; j++) begin
            if (b >= knot_count) begin
                row = knot_count - 1;
                bt.value = knot_vals[row][j];
            end else begin
                bt.value = blend(knot_vals[b-1][j], knot_vals[b][j], t - knot_times[b-1],
                                 knot_times[b] - knot_times[b-1]);
            end
            bt.index = 3'(j);
            bt.status = sti_pkg::ST_OK;
            bt.last = (j + 1 == n);
            expected_results = {expected_results, bt};
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Issues one request in the sender's burst pattern and records its beats.
    task automatic send_req(sti_pkg::req_t rq, logic [31:0] ts, logic [31:0] val,
                            bit typed, sti_pkg::status_t st);
        int gap;
        beat_t bt;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_req_type = rq;
        s_time_stamp = ts;
        s_comp_value = val;
        do @(posedge aclk); while (!s_ready);
        interp_predict(rq, ts, val);
        if (typed) begin
            // The beat is known outright; the shadow state has still advanced.
            bt = '{32'd0, 3'd0, st, 1'b1};
            expected_results[expected_results.size() - 1] = bt;
        end
    endtask

    task automatic hold_sender();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
    endtask

    // Register write once the block has drained.
    task automatic write_comp_cfg(logic [3:0] d);
        hold_sender();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = d;
        @(negedge aclk);
        cfg_we = 1'b0;
        comp_cfg = d;
        comp_fill = 0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(-$signed({1'b0, $urandom_range(255, 0)}));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] next_time(int unsigned step_max);
        logic [31:0] base;
        base = (knot_count > 0) ? knot_times[knot_count-1] : 32'd100;
        return base + $urandom_range(step_max, 1);
    endfunction

    task automatic send_sample(logic [31:0] t);
        int unsigned n;
        n = live_comps();
        for (int unsigned j = 0; j < n; j++)
            send_req(sti_pkg::REQ_APPEND, (j == 0) ? t : $urandom, pick_value(), 1'b0,
                     sti_pkg::ST_OK);
    endtask

    task automatic send_query_in_span();
        logic [31:0] t;
        if (knot_count < 2) return;
        if ($urandom_range(0, 4) == 0) t = knot_times[$urandom_range(knot_count - 1, 0)];
        else t = $urandom_range(knot_times[knot_count-1], knot_times[0]);
        if (query_reads_written(t))
            send_req(sti_pkg::REQ_QUERY, t, $urandom, 1'b0, sti_pkg::ST_OK);
    endtask

    task automatic send_query_outside();
        logic [31:0] t;
        if (knot_count > 0 && $urandom_range(0, 1) == 0 && knot_times[0] > 0)
            t = $urandom_range(knot_times[0] - 1, 0);
        else if (knot_count > 0 && knot_times[knot_count-1] != 32'hFFFF_FFFF)
            t = $urandom_range(32'hFFFF_FFFF, knot_times[knot_count-1] + 1);
        else
            t = 32'd0;
        send_req(sti_pkg::REQ_QUERY, t, $urandom, 1'b0, sti_pkg::ST_OK);
    endtask

    // Mostly well-formed samples and queries inside the table, with some noise.
    task automatic run_phase(int budget);
        int issued;
        int unsigned r;
        int unsigned n;
        issued = 0;
        n = live_comps();
        while (issued < budget) begin
            r = $urandom_range(99, 0);
            if (r < 45) begin
                send_sample(next_time(2000000));
                issued += n;
            end else if (r < 52 && knot_count > 0) begin
                send_sample($urandom_range(knot_times[knot_count-1], 0));
                issued += n;
            end else if (r < 90) begin
                send_query_in_span();
                issued++;
            end else begin
                send_query_outside();
                issued++;
            end
        end
        // Leave a partial sample for the next register write to drop.
        if (n > 1) begin
            for (int unsigned j = 0; j < $urandom_range(n - 1, 1); j++)
                send_req(sti_pkg::REQ_APPEND, next_time(1000), pick_value(), 1'b0,
                         sti_pkg::ST_OK);
        end
    endtask

    // Receiver: stretches of random stalls alternate with stretches always ready.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = ~stall_mode;
            stall_left = $urandom_range(128, 16);
        end
        stall_left--;
        m_ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    // Output checking and the idle watchdog.
    always @(posedge aclk) begin
        beat_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", m_out_value, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_out_value !== want.value)
                        report_mismatch("out_value", m_out_value, want.value);
                    if (m_comp_index !== want.index)
                        report_mismatch("comp_index", 32'(m_comp_index), 32'(want.index));
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_last !== want.last)
                        report_mismatch("last", 32'(m_last), 32'(want.last));
                end
            end
            if (idle_cycles >= IdleLimit) begin
                $display("sampled_trajectory_interpolator verification failed");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < sti_pkg::MaxSamples; i++) knot_written[i] = '0;
        knot_count = 0;
        comp_fill = 0;
        held_time = 32'd0;
        comp_cfg = 4'd1;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table, with the reset value of the register.
        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].ts, dir_rows[i].val,
                     dir_rows[i].typed, dir_rows[i].status);

        // Register settings run from wide to narrow, so no query meets unwritten rows.
        write_comp_cfg(4'd15);
        run_phase(40);
        write_comp_cfg(4'd8);
        run_phase(35);
        write_comp_cfg(4'd5);
        run_phase(30);
        write_comp_cfg(4'd3);
        run_phase(25);
        write_comp_cfg(4'd2);
        run_phase(20);

        // Single component: a few more samples, ending on the largest time.
        write_comp_cfg(4'd0);
        for (int i = 0; i < 12; i++) begin
            send_req(sti_pkg::REQ_APPEND, next_time(1000), pick_value(), 1'b0,
                     sti_pkg::ST_OK);
            if ($urandom_range(0, 3) == 0) send_query_in_span();
        end
        send_req(sti_pkg::REQ_APPEND, 32'hFFFF_FFFF, pick_value(), 1'b1,
                 sti_pkg::ST_ACCEPTED);
        send_req(sti_pkg::REQ_APPEND, 32'hFFFF_FFFF, pick_value(), 1'b1,
                 sti_pkg::ST_REJECTED);
        send_req(sti_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'd0, 1'b0, sti_pkg::ST_OK);
        for (int i = 0; i < 10; i++) send_query_in_span();
        send_query_outside();

        hold_sender();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("sampled_trajectory_interpolator verification clean");
        end else begin
            $display("sampled_trajectory_interpolator verification failed");
        end
        $finish;
    end

endmodule
